@@ hdl/multi_level_bounded_stack_unit_macros.svh @@
// assertion macros for the multi-level bounded stack unit
// included by the top level only; no other dependencies
`ifndef MULTI_LEVEL_BOUNDED_STACK_UNIT_MACROS_SVH
`define MULTI_LEVEL_BOUNDED_STACK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define MLBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// antecedent holds -> consequent holds in the next cycle
`define MLBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define MLBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MLBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/mlbs_pkg.sv @@
// shared constants, codes and types for the multi-level bounded stack unit
// no dependencies
package mlbs_pkg;

    localparam int LEVELS = 10;
    localparam int DEPTH  = 10;

    localparam int LEVEL_W = 4;
    localparam int VALUE_W = 32;
    localparam int ENTRY_W = 4;
    localparam int STAT_W  = 2;

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORDS  = LEVELS * DEPTH;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADLEVEL = 2'd3;

    // memory access issued on request acceptance
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [VALUE_W-1:0] wdata;
    } ram_req_t;

    // per-request result info held while the memory read completes
    typedef struct packed {
        logic               pop_ok;
        logic [STAT_W-1:0]  status;
        logic [ENTRY_W-1:0] entries_left;
    } stage_info_t;

endpackage

@@ hdl/mlbs_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module mlbs_ram #(
    parameter int DATA_W = 32,
    parameter int WORDS  = 100
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                       wr_data,
    input  logic                                    rd_en,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                       rd_data
);

    logic [DATA_W-1:0] mem_reg [WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/mlbs_ctrl.sv @@
// per-level fill counters, request decode and memory addressing
// depends on mlbs_pkg
module mlbs_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_fire,
    input  logic                           op,
    input  logic [mlbs_pkg::LEVEL_W-1:0]   level,
    input  logic [mlbs_pkg::VALUE_W-1:0]   push_value,
    output mlbs_pkg::ram_req_t             ram_req,
    output mlbs_pkg::stage_info_t          info
);
    import mlbs_pkg::*;

    localparam int EXT_W = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;

    logic [CNT_W-1:0] count_reg [LEVELS];
    stage_info_t      info_reg;
    stage_info_t      info_next;

    logic             bad_level;
    logic [LVL_W-1:0] lvl_idx;
    logic [CNT_W-1:0] cnt_cur;
    logic [CNT_W-1:0] cnt_after;
    logic [CNT_W-1:0] slot;
    logic             push_ok;
    logic             pop_ok;
    logic [EXT_W-1:0] cnt_ext;

    assign bad_level = ({1'b0, level} >= (LEVEL_W + 1)'(LEVELS));
    assign lvl_idx   = bad_level ? '0 : level[LVL_W-1:0];
    assign cnt_cur   = count_reg[lvl_idx];

    always_comb begin
        push_ok   = 1'b0;
        pop_ok    = 1'b0;
        slot      = cnt_cur;
        cnt_after = cnt_cur;
        info_next = '0;
        if (bad_level) begin
            info_next.status = ST_BADLEVEL;
        end else if (op == OP_POP) begin
            if (cnt_cur == '0) begin
                info_next.status = ST_EMPTY;
            end else begin
                pop_ok    = 1'b1;
                slot      = cnt_cur - 1'b1;
                cnt_after = cnt_cur - 1'b1;
                info_next.status = ST_DONE;
            end
        end else begin
            if (cnt_cur >= CNT_W'(DEPTH)) begin
                info_next.status = ST_FULL;
            end else begin
                push_ok   = 1'b1;
                cnt_after = cnt_cur + 1'b1;
                info_next.status = ST_DONE;
            end
        end
        info_next.pop_ok = pop_ok;
        cnt_ext = EXT_W'(cnt_after);
        if (bad_level) begin
            info_next.entries_left = '0;
        end else if (cnt_ext > EXT_W'(15)) begin
            info_next.entries_left = '1;
        end else begin
            info_next.entries_left = cnt_ext[ENTRY_W-1:0];
        end
    end

    // level base plus slot within the level
    assign ram_req.wr_en = in_fire && push_ok;
    assign ram_req.rd_en = in_fire && pop_ok;
    assign ram_req.addr  = ADDR_W'(ADDR_W'(lvl_idx) * ADDR_W'(DEPTH)) + ADDR_W'(slot);
    assign ram_req.wdata = push_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (in_fire && (push_ok || pop_ok)) begin
            count_reg[lvl_idx] <= cnt_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            info_reg <= info_next;
        end
    end

    assign info = info_reg;

endmodule

@@ hdl/mlbs_out.sv @@
// result register: merges read data with held request info, drives the result channel
// depends on mlbs_pkg
module mlbs_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s1_valid,
    input  mlbs_pkg::stage_info_t         info,
    input  logic [mlbs_pkg::VALUE_W-1:0]  rd_data,
    output logic                          take,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,
    output logic [mlbs_pkg::STAT_W-1:0]   m_tuser
);
    import mlbs_pkg::*;

    logic                 valid_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [ENTRY_W-1:0]   entries_reg;

    assign take = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && s1_valid) begin
            value_reg   <= info.pop_ok ? rd_data : '0;
            status_reg  <= info.status;
            entries_reg <= info.entries_left;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, entries_reg, value_reg};
    assign m_tuser  = status_reg;

endmodule

@@ hdl/multi_level_bounded_stack_unit.sv @@
// top level of the multi-level bounded stack unit
// depends on mlbs_pkg, mlbs_ctrl, mlbs_ram, mlbs_out and the assertion macro header
//
// usage:
//   a bank of LEVELS stacks, each DEPTH words deep, kept in one shared ram.
//   request channel (s_): s_tuser carries operation (push 0, pop 1) and level,
//   s_tdata carries the value to push. result channel (m_): s_tdata-like
//   m_tdata carries the popped value and the entries left on that level,
//   m_tuser carries the status (done, full, empty, bad level).
//   a full push or empty pop is refused and reported, never waited on.
//   the counters are read and updated and the ram is accessed at request
//   acceptance, the ram read data lands in the following cycle and is
//   merged into the result register. throughput is one request per cycle
//   while the receiver keeps up; the ram has one access per request, so
//   back-to-back pushes and pops on the same level see each other in
//   order without forwarding.
//   reset clears all level counters and empties both pipeline stages; the
//   ram contents are left as they are and only written slots are ever read.
//   when the receiver stalls, the result register holds and one more request
//   is held in the middle stage; s_tready drops once both are full.
`include "multi_level_bounded_stack_unit_macros.svh"

module multi_level_bounded_stack_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [4:0]  s_tuser,   // [0] operation, [4:1] level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] pop_value, [35:32] entries_left, [39:36] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import mlbs_pkg::*;

    logic        in_fire;
    logic        out_take;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    ram_req_t    ram_req;
    stage_info_t info;
    logic [VALUE_W-1:0] rd_data;

    // accept a request whenever the middle stage is empty or moving on
    assign s_tready = !s1_valid_reg || out_take;
    assign in_fire  = s_tvalid && s_tready;

    mlbs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .op         (s_tuser[0]),
        .level      (s_tuser[4:1]),
        .push_value (s_tdata),
        .ram_req    (ram_req),
        .info       (info)
    );

    // one word per slot, level-major
    mlbs_ram #(
        .DATA_W (VALUE_W),
        .WORDS  (WORDS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.addr),
        .wr_data (ram_req.wdata),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.addr),
        .rd_data (rd_data)
    );

    // middle stage valid: set on acceptance, cleared when handed to the result register
    always_comb begin
        if (in_fire) begin
            s1_valid_next = 1'b1;
        end else if (out_take) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    mlbs_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1_valid (s1_valid_reg),
        .info     (info),
        .rd_data  (rd_data),
        .take     (out_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // an accepted request always occupies the middle stage next cycle
    `MLBS_ASSERT_NEXT(a_fire_fills_stage, aclk, aresetn, in_fire, s1_valid_reg)
    // refused or bad requests never return data
    `MLBS_ASSERT_IMPLY(a_refused_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_DONE), m_tdata[31:0] == '0)
    // bad level reports no entries
    `MLBS_ASSERT_IMPLY(a_bad_no_entries, aclk, aresetn, m_tvalid && (m_tuser == ST_BADLEVEL), m_tdata[35:32] == '0)
    // ram never asked to read and write for one request
    `MLBS_ASSERT_IMPLY(a_one_access, aclk, aresetn, ram_req.wr_en, !ram_req.rd_en)

endmodule

@@ verif/tb.sv @@
// self-checking testbench for multi_level_bounded_stack_unit: directed and random
// push/pop requests against a behavioral stack bank, with random idling on both sides
// depends on mlbs_pkg and the unit's rtl
`timescale 1ns / 1ps

module tb;
    import mlbs_pkg::*;

    // one predicted result
    typedef struct {
        logic [VALUE_W-1:0] pop_value;
        logic [STAT_W-1:0]  status;
        logic [ENTRY_W-1:0] entries_left;
    } stack_result_t;

    // behavioral copy of the stack bank plus the queue of predicted results
    class stack_scoreboard;
        logic [VALUE_W-1:0] slots [LEVELS][DEPTH];
        int unsigned        fill [LEVELS];
        stack_result_t      expected_q [$];
        int unsigned        mismatches;

        function new();
            foreach (fill[i]) fill[i] = 0;
            mismatches = 0;
        endfunction

        function void report_mismatch(string what);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", what);
        endfunction

        // apply an accepted request and queue the result it should give
        function void note_request(logic op, logic [LEVEL_W-1:0] lvl,
                                   logic [VALUE_W-1:0] value);
            stack_result_t r;
            int unsigned   n;
            r.pop_value    = '0;
            r.status       = ST_DONE;
            r.entries_left = '0;
            if (lvl >= LEVELS) begin
                r.status = ST_BADLEVEL;
            end else begin
                n = fill[lvl];
                if (op == OP_POP) begin
                    if (n == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        n--;
                        r.pop_value = slots[lvl][n];
                        fill[lvl]   = n;
                    end
                end else begin
                    if (n >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        slots[lvl][n] = value;
                        n++;
                        fill[lvl] = n;
                    end
                end
                // count field saturates for deep stacks
                r.entries_left = (n > 15) ? 4'd15 : ENTRY_W'(n);
            end
            expected_q.push_back(r);
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(logic [39:0] tdata, logic [STAT_W-1:0] tuser);
            stack_result_t r;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: tdata %h tuser %0d",
                                          tdata, tuser));
                return;
            end
            r = expected_q.pop_front();
            if (tdata[31:0] !== r.pop_value || tuser !== r.status ||
                tdata[35:32] !== r.entries_left || tdata[39:36] !== 4'b0)
                report_mismatch($sformatf(
                    {"pop_value exp %h act %h, status exp %0d act %0d, ",
                     "entries exp %0d act %0d, pad %h"},
                    r.pop_value, tdata[31:0], r.status, tuser,
                    r.entries_left, tdata[35:32], tdata[39:36]));
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] push_value
    logic [4:0]  s_tuser;   // [0] operation, [4:1] level
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] pop_value, [35:32] entries_left, [39:36] zero
    logic [1:0]  m_tuser;   // [1:0] status

    int unsigned     send_idle_pct;
    int unsigned     recv_stall_pct;
    stack_scoreboard board;

    multi_level_bounded_stack_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: check on handshake, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // drive one request, with optional idle cycles first, and wait for acceptance
    task automatic send_request(logic op, logic [LEVEL_W-1:0] lvl, logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {lvl, op};
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        board.note_request(op, lvl, value);
    endtask

    // extremes, every status, and a level filled past its limit
    task automatic run_directed();
        logic [VALUE_W-1:0] edge_vals [4];
        edge_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
        send_request(OP_POP, '0, $urandom);                     // pop from empty level
        foreach (edge_vals[i]) send_request(OP_PUSH, '0, edge_vals[i]);
        foreach (edge_vals[i]) send_request(OP_POP, '0, $urandom);
        send_request(OP_PUSH, 4'd15, 32'h1234_5678);             // bad level
        send_request(OP_POP, LEVEL_W'(LEVELS), $urandom);
        repeat (DEPTH) send_request(OP_PUSH, LEVEL_W'(LEVELS - 1), $urandom);
        send_request(OP_PUSH, LEVEL_W'(LEVELS - 1), $urandom);   // push on full level
        send_request(OP_POP, LEVEL_W'(LEVELS - 1), $urandom);
    endtask

    // random traffic: push bias and a hot level shift every 40 requests so levels
    // run all the way to full and back to empty
    task automatic run_random(int unsigned count);
        int unsigned         push_pct;
        logic [LEVEL_W-1:0]  hot_level;
        logic [LEVEL_W-1:0]  lvl;
        logic                op;
        push_pct  = 50;
        hot_level = '0;
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    default: push_pct = 80;
                endcase
                hot_level = LEVEL_W'($urandom_range(LEVELS - 1));
            end
            if (LEVELS < 16 && $urandom_range(99) < 10)
                lvl = LEVEL_W'($urandom_range(15, LEVELS));
            else if ($urandom_range(99) < 50)
                lvl = hot_level;
            else
                lvl = LEVEL_W'($urandom_range(LEVELS - 1));
            op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            send_request(op, lvl, $urandom);
        end
    endtask

    initial begin
        board          = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles lightly, receiver stalls heavily
        send_idle_pct  = 19;
        recv_stall_pct = 66;
        run_directed();
        run_random(330);
        // the other way round
        send_idle_pct  = 66;
        recv_stall_pct = 19;
        run_random(335);
        // full rate both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(335);
        s_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        board.close_out();
        if (board.mismatches == 0)
            $display("multi_level_bounded_stack_unit regression: pass");
        else
            $display("multi_level_bounded_stack_unit regression: fail");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("multi_level_bounded_stack_unit regression: fail");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/mlbs_pkg.sv
hdl/mlbs_ram.sv
hdl/mlbs_ctrl.sv
hdl/mlbs_out.sv
hdl/multi_level_bounded_stack_unit.sv
verif/tb.sv
